// ===== hw/rtl/lcbt_pkg.sv =====
package lcbt_pkg;

    localparam int LEN_W  = 10;
    localparam int BIN_W  = 3;
    localparam int WORD_W = 32;
    localparam int SUB_W  = $clog2(WORD_W);
    localparam int OFF_W  = SUB_W + 1;
    localparam int T36_W  = 18;

    localparam logic [LEN_W-1:0] LEN_RESET = 10'd500;

    typedef logic [LEN_W-1:0]         t_len;
    typedef logic [BIN_W-1:0]         t_bin;
    typedef logic [WORD_W-1:0]        t_word;
    typedef logic signed [T36_W-1:0]  t_t36;

    // Bin edges of 36*T, and the constant term of 36*T for an odd block length.
    localparam t_t36 T36_LIM0    = -18'sd90;
    localparam t_t36 T36_LIM1    = -18'sd54;
    localparam t_t36 T36_LIM2    = -18'sd18;
    localparam t_t36 T36_LIM3    = 18'sd18;
    localparam t_t36 T36_LIM4    = 18'sd54;
    localparam t_t36 T36_LIM5    = 18'sd90;
    localparam t_t36 T36_ODD_ADJ = 18'sd18;

endpackage

// ===== hw/rtl/lcbt_ram.sv =====
module lcbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lcbt_alu.sv =====
module lcbt_alu import lcbt_pkg::*; (
    input  t_word             i_hi,
    input  t_word             i_lo,
    input  logic [OFF_W-1:0]  i_off,
    input  t_word             i_coef,
    input  t_word             i_mask,
    output logic              o_parity,
    output t_word             o_sum
);

    logic [2*WORD_W-1:0] cat;
    t_word               shifted;
    t_word               reversed;

    // Funnel shift over two adjacent words; the discrepancy pass needs the
    // window in reverse bit order, the update pass takes it as it is.
    assign cat     = {i_hi, i_lo};
    assign shifted = cat[i_off +: WORD_W];

    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            reversed[i] = shifted[WORD_W-1-i];
        end
    end

    assign o_parity = ^(i_coef & reversed & i_mask);
    assign o_sum    = i_coef ^ shifted;

endmodule

// ===== hw/rtl/lcbt_bin.sv =====
module lcbt_bin import lcbt_pkg::*; (
    input  t_len i_complexity,
    input  t_len i_block_len,
    output t_bin o_bin_index
);

    t_t36 l36;
    t_t36 m18;
    t_t36 t36;

    // 36*L and 18*M as shift-and-add.
    assign l36 = T36_W'({i_complexity, 5'b0}) + T36_W'({i_complexity, 2'b0});
    assign m18 = T36_W'({i_block_len, 4'b0}) + T36_W'({i_block_len, 1'b0});
    assign t36 = i_block_len[0] ? (m18 - l36 + T36_ODD_ADJ) : (l36 - m18);

    always_comb begin
        priority if (t36 <= T36_LIM0) begin
            o_bin_index = 3'd0;
        end else if (t36 <= T36_LIM1) begin
            o_bin_index = 3'd1;
        end else if (t36 <= T36_LIM2) begin
            o_bin_index = 3'd2;
        end else if (t36 <= T36_LIM3) begin
            o_bin_index = 3'd3;
        end else if (t36 <= T36_LIM4) begin
            o_bin_index = 3'd4;
        end else if (t36 <= T36_LIM5) begin
            o_bin_index = 3'd5;
        end else begin
            o_bin_index = 3'd6;
        end
    end

endmodule

// ===== hw/rtl/linear_complexity_block_tester.sv =====
// Takes one bit per beat while busy is low; busy rises after the accepting edge and stays high
// through the discrepancy pass over n words, n = floor(min(L, position)/32) + 1, and, when the
// discrepancy is one, through the update pass over WORDS words, WORDS = MAX_BLOCK/32 rounded up.
// The shared 32-bit funnel unit walks the polynomial memories one word a cycle.
// The result strobe is high in the first cycle with busy low; the receiver cannot stall it.
// Synchronous active-low reset; polynomial rows read as their reset value via row valid bits.
module linear_complexity_block_tester import lcbt_pkg::*; #(
    parameter int MAX_BLOCK = 512
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  logic i_bit_value,
    input  logic i_cfg_wr_en,
    input  t_len i_cfg_wr_data,
    output logic o_result_valid,
    output t_len o_complexity,
    output t_bin o_bin_index
);

    localparam int WORDS = (MAX_BLOCK + WORD_W - 1) / WORD_W;
    localparam int AW    = $clog2(WORDS);
    localparam int CW    = $clog2(WORDS + 1);
    localparam int SAW   = AW + 8;
    localparam int JW    = (CW + SUB_W > LEN_W) ? CW + SUB_W : LEN_W;
    localparam int SH_W  = LEN_W + 2;
    localparam int MAXC  = (MAX_BLOCK < 1023) ? MAX_BLOCK : 1023;

    localparam t_len                  MAXC_V   = LEN_W'(MAXC);
    localparam logic [CW-1:0]         WORDS_C  = CW'(WORDS);
    localparam logic signed [SAW-1:0] WORDS_M1 = SAW'(WORDS - 1);
    localparam t_word                 WORD_ONE = WORD_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HWR,
        S_DPRIME,
        S_DWALK,
        S_DECIDE,
        S_UPRIME,
        S_UWALK,
        S_FIN
    } t_state;

    t_state                r_state;
    t_len                  r_len_cfg;
    t_len                  r_pos;
    t_len                  r_L;
    logic [LEN_W:0]        r_lc;
    t_len                  r_jm;
    t_word                 r_hcur;
    logic                  r_d;
    logic                  r_chg;
    logic [SUB_W-1:0]      r_ql;
    logic signed [SAW-1:0] r_sbase;
    logic [CW-1:0]         r_n;
    logic [CW-1:0]         r_k;
    t_word                 r_prev;
    logic                  r_s_neg;
    logic                  r_s_vld;
    logic                  r_s_row0;
    logic                  r_c_vld;
    logic                  r_c_row0;
    logic [WORDS-1:0]      r_cvld;
    logic [WORDS-1:0]      r_bvld;
    logic                  r_o_valid;
    t_len                  r_o_cplx;
    t_bin                  r_o_bin;

    t_len                  eff_len;
    logic                  phase_d;
    logic                  prime;
    logic                  walk;
    logic                  issuing;
    logic                  proc;
    logic signed [SAW-1:0] issue_k;
    logic signed [SAW-1:0] sa;
    logic                  sa_neg;
    logic [AW-1:0]         sa_idx;
    logic [CW-1:0]         ca_full;
    logic [AW-1:0]         ca_idx;
    logic [CW-1:0]         pw;
    logic [AW-1:0]         pw_idx;
    logic [AW-1:0]         hw_addr;
    t_word                 h_rdata;
    t_word                 c_rdata;
    t_word                 b_rdata;
    t_word                 s_eff;
    t_word                 c_eff;
    logic [OFF_W-1:0]      alu_off;
    t_word                 alu_mask;
    logic                  alu_par;
    t_word                 alu_sum;
    logic [SH_W-1:0]       shift_u;
    logic [SH_W-1:0]       shift_sum;
    logic [SH_W-1:0]       neg_shift;
    t_len                  jm_now;
    logic                  chg_now;
    t_len                  new_len;
    logic                  blk_end;
    t_bin                  bin_now;

    always_comb begin
        if (r_len_cfg == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_len_cfg > MAXC_V) begin
            eff_len = MAXC_V;
        end else begin
            eff_len = r_len_cfg;
        end
    end

    assign phase_d = (r_state == S_DPRIME) || (r_state == S_DWALK);
    assign prime   = (r_state == S_DPRIME) || (r_state == S_UPRIME);
    assign walk    = (r_state == S_DWALK) || (r_state == S_UWALK);
    assign issuing = prime || (walk && (r_k != r_n));
    assign proc    = walk && (r_k != '0);

    // The stream memory (history or previous polynomial) runs one word ahead of
    // the connection polynomial; the priming read fetches that extra word.
    assign issue_k = prime ? '1 : SAW'(r_k);
    assign sa      = r_sbase - issue_k;
    assign sa_neg  = sa[SAW-1];
    assign sa_idx  = sa[AW-1:0];

    assign ca_full = phase_d ? r_k : (WORDS_C - CW'(1) - r_k);
    assign ca_idx  = ca_full[AW-1:0];
    assign pw      = phase_d ? (r_k - CW'(1)) : (WORDS_C - r_k);
    assign pw_idx  = pw[AW-1:0];
    assign hw_addr = AW'(r_pos[LEN_W-1:SUB_W]);

    always_comb begin
        if (r_s_neg) begin
            s_eff = '0;
        end else if (r_s_vld) begin
            s_eff = phase_d ? h_rdata : b_rdata;
        end else begin
            s_eff = r_s_row0 ? WORD_ONE : '0;
        end
    end

    assign c_eff = r_c_vld ? c_rdata : (r_c_row0 ? WORD_ONE : '0);

    assign alu_off = phase_d ? ({1'b0, r_pos[SUB_W-1:0]} + OFF_W'(1)) : {1'b0, r_ql};

    // Only taps 1..min(L, position) take part in the discrepancy.
    always_comb begin
        logic [JW-1:0] j;
        for (int i = 0; i < WORD_W; i++) begin
            j           = JW'({pw, SUB_W'(i)});
            alu_mask[i] = (j != '0) && (j <= JW'(r_jm));
        end
    end

    assign shift_u   = {2'b00, r_pos} - {r_lc[LEN_W], r_lc};
    assign shift_sum = shift_u + SH_W'(WORD_W - 1);
    assign neg_shift = SH_W'(0) - shift_u;
    assign jm_now    = (r_L < r_pos) ? r_L : r_pos;
    assign chg_now   = r_L <= {1'b0, r_pos[LEN_W-1:1]};
    assign new_len   = r_pos + LEN_W'(1) - r_L;
    assign blk_end   = ({1'b0, r_pos} + (LEN_W+1)'(1)) >= {1'b0, eff_len};

    lcbt_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (r_state == S_HWR),
        .i_waddr (hw_addr),
        .i_wdata (r_hcur),
        .i_raddr (sa_idx),
        .o_rdata (h_rdata)
    );

    lcbt_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_conn (
        .i_clk   (i_clk),
        .i_we    (proc && !phase_d),
        .i_waddr (pw_idx),
        .i_wdata (alu_sum),
        .i_raddr (ca_idx),
        .o_rdata (c_rdata)
    );

    lcbt_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_prev (
        .i_clk   (i_clk),
        .i_we    (proc && !phase_d && r_chg),
        .i_waddr (pw_idx),
        .i_wdata (c_eff),
        .i_raddr (sa_idx),
        .o_rdata (b_rdata)
    );

    lcbt_alu u_alu (
        .i_hi     (r_prev),
        .i_lo     (s_eff),
        .i_off    (alu_off),
        .i_coef   (c_eff),
        .i_mask   (alu_mask),
        .o_parity (alu_par),
        .o_sum    (alu_sum)
    );

    lcbt_bin u_bin (
        .i_complexity (r_L),
        .i_block_len  (eff_len),
        .o_bin_index  (bin_now)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len_cfg <= LEN_RESET;
            r_pos     <= '0;
            r_L       <= '0;
            r_lc      <= '1;
            r_jm      <= '0;
            r_d       <= 1'b0;
            r_chg     <= 1'b0;
            r_n       <= '0;
            r_k       <= '0;
            r_cvld    <= '0;
            r_bvld    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= (r_state == S_FIN) && blk_end;
            if (i_cfg_wr_en) begin
                r_len_cfg <= i_cfg_wr_data;
            end
            if (issuing) begin
                r_s_neg  <= sa_neg;
                r_s_vld  <= phase_d ? 1'b1 : (!sa_neg && r_bvld[sa_idx]);
                r_s_row0 <= !phase_d && (sa == '0);
                r_c_vld  <= r_cvld[ca_idx];
                r_c_row0 <= (ca_idx == '0);
            end
            if (walk) begin
                r_prev <= s_eff;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_hcur[r_pos[SUB_W-1:0]] <= i_bit_value;
                        r_d     <= i_bit_value;
                        r_jm    <= jm_now;
                        r_n     <= CW'({1'b0, jm_now[LEN_W-1:SUB_W]}) + CW'(1);
                        r_k     <= '0;
                        r_sbase <= SAW'({1'b0, r_pos[LEN_W-1:SUB_W]}) - SAW'(1);
                        r_state <= S_HWR;
                    end
                end
                S_HWR: begin
                    r_state <= S_DPRIME;
                end
                S_DPRIME: begin
                    r_state <= S_DWALK;
                end
                S_DWALK: begin
                    if (proc) begin
                        r_d <= r_d ^ alu_par;
                    end
                    if (r_k == r_n) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_k <= r_k + CW'(1);
                    end
                end
                S_DECIDE: begin
                    if (r_d) begin
                        r_chg   <= chg_now;
                        r_ql    <= neg_shift[SUB_W-1:0];
                        r_sbase <= WORDS_M1 - SAW'(shift_sum[SH_W-2:SUB_W]);
                        r_n     <= WORDS_C;
                        r_k     <= '0;
                        r_state <= S_UPRIME;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_UPRIME: begin
                    r_state <= S_UWALK;
                end
                S_UWALK: begin
                    if (proc) begin
                        r_cvld[pw_idx] <= 1'b1;
                        if (r_chg) begin
                            r_bvld[pw_idx] <= 1'b1;
                        end
                    end
                    if (r_k == r_n) begin
                        if (r_chg) begin
                            r_L  <= new_len;
                            r_lc <= {1'b0, r_pos};
                        end
                        r_state <= S_FIN;
                    end else begin
                        r_k <= r_k + CW'(1);
                    end
                end
                S_FIN: begin
                    if (blk_end) begin
                        r_o_cplx  <= r_L;
                        r_o_bin   <= bin_now;
                        r_L       <= '0;
                        r_lc      <= '1;
                        r_pos     <= '0;
                        r_cvld    <= '0;
                        r_bvld    <= '0;
                    end else begin
                        r_pos <= r_pos + LEN_W'(1);
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_o_valid;
    assign o_complexity   = r_o_cplx;
    assign o_bin_index    = r_o_bin;

endmodule
